>>> hdl/utf8sd_pkg.sv
// Package for the streaming UTF-8 decoder: byte-class limits, field masks,
// output packing widths and the default character-count width.
// No dependencies.
package utf8sd_pkg;

	// Byte classes where a lead byte is due.
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MIN   = 8'hC0;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD_MAX    = 8'hF7;

	// Payload masks for lead and continuation bytes.
	localparam logic [7:0] CONT_MASK  = 8'h3F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;

	// Field widths.
	localparam int CP_W        = 21;
	localparam int COUNT_OUT_W = 16;
	localparam int TDATA_OUT_W = 40;   // 21 + 16 = 37 bits, padded to bytes
	localparam int TUSER_OUT_W = 3;

	// Bit positions in the output tuser.
	localparam int USER_CHAR_DONE = 0;
	localparam int USER_BAD_LEAD  = 1;
	localparam int USER_STRING_OK = 2;

	localparam int COUNT_BITS_DEFAULT = 16;

	// Continuation bytes still due for the current character.
	typedef logic [1:0] bytes_left_t;

	// Flags of one result.
	typedef struct packed {
		logic string_ok;
		logic bad_lead;
		logic char_done;
	} result_flags_t;

endpackage

>>> hdl/utf8_stream_decoder.sv
// Streaming UTF-8 decoder, top level: decode logic, per-string state and
// the output register. Depends on utf8sd_pkg.
module utf8_stream_decoder #(
	parameter int COUNT_BITS = utf8sd_pkg::COUNT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: cfg_data bit 0 is utf8_enable.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,

	// Input bytes.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_string

	// Results.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [utf8sd_pkg::TDATA_OUT_W-1:0] m_axis_tdata, // [20:0] code_point,
	                                                          // [36:21] char_count,
	                                                          // [39:37] zero
	output logic [utf8sd_pkg::TUSER_OUT_W-1:0] m_axis_tuser, // [0] char_done,
	                                                          // [1] bad_lead,
	                                                          // [2] string_ok
	output logic        m_axis_tlast    // string_end
);
	// How to use this block:
	// Bytes of a string enter on the s_axis channel, one item per byte, with
	// tlast on the string's last byte. Each accepted item updates the decode
	// state in the same cycle and, when it completes a character, is an
	// illegal lead byte or ends the string, loads one result item into the
	// output register. Bytes that only start or extend a character give no
	// result. A result appears on m_axis in the cycle after its byte is
	// accepted, and one byte per cycle is sustained: s_axis_tready stays high
	// while the output register is empty or is being drained in the same
	// cycle. When the receiver stalls with a result waiting, s_axis_tready
	// drops and the result holds until taken. Reset clears the decode state
	// and the output valid flag, and sets utf8_enable to 1. The configuration
	// channel is always ready; write it only while no string is in flight.
	// The character count saturates at 2^COUNT_BITS - 1 and is reported in
	// 16 bits; at string end the per-string state is cleared.

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam int CP_W = utf8sd_pkg::CP_W;
	localparam int CNT_W = utf8sd_pkg::COUNT_OUT_W;

	// Configuration and per-string state.
	logic                    utf8_enable_q;
	utf8sd_pkg::bytes_left_t bytes_left_q;
	logic [CP_W-1:0]         acc_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic                    error_q;

	// Output register.
	logic                      out_valid_q;
	logic [CP_W-1:0]           cp_q;
	logic [CNT_W-1:0]          count_out_q;
	utf8sd_pkg::result_flags_t flags_q;
	logic                      last_q;

	// Decode of the incoming byte.
	logic                      in_fire;
	logic [7:0]                b;
	logic                      last;
	logic                      done;
	logic                      bad;
	logic [CP_W-1:0]           cp;
	utf8sd_pkg::bytes_left_t   bytes_left_d;
	logic [CP_W-1:0]           acc_d;
	logic                      error_d;
	logic [COUNT_BITS-1:0]     count_d;
	logic                      ok;
	logic                      emit;
	logic [CNT_W-1:0]          count_out;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign last          = s_axis_tlast;

	always_comb begin
		done         = 1'b0;
		bad          = 1'b0;
		cp           = '0;
		bytes_left_d = bytes_left_q;
		acc_d        = acc_q;
		error_d      = error_q;
		if (bytes_left_q != 2'd0) begin
			// Continuation byte: its low six bits are shifted in unchecked.
			acc_d        = {acc_q[CP_W-7:0], b[5:0] & utf8sd_pkg::CONT_MASK[5:0]};
			bytes_left_d = bytes_left_q - 2'd1;
			if (bytes_left_q == 2'd1) begin
				done = 1'b1;
				cp   = acc_d;
			end
		end else if (!utf8_enable_q || b < utf8sd_pkg::ASCII_LIMIT) begin
			done = 1'b1;
			cp   = {{(CP_W-8){1'b0}}, b};
		end else if (b < utf8sd_pkg::LEAD2_MIN || b > utf8sd_pkg::LEAD_MAX) begin
			bad     = 1'b1;
			error_d = 1'b1;
		end else if (b < utf8sd_pkg::LEAD3_MIN) begin
			acc_d        = {{(CP_W-8){1'b0}}, b & utf8sd_pkg::LEAD2_MASK};
			bytes_left_d = 2'd1;
		end else if (b < utf8sd_pkg::LEAD4_MIN) begin
			acc_d        = {{(CP_W-8){1'b0}}, b & utf8sd_pkg::LEAD3_MASK};
			bytes_left_d = 2'd2;
		end else begin
			acc_d        = {{(CP_W-8){1'b0}}, b & utf8sd_pkg::LEAD4_MASK};
			bytes_left_d = 2'd3;
		end
	end

	assign count_d = (done && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign ok      = last && !error_d && bytes_left_d == 2'd0;
	assign emit    = done || bad || last;

	// The reported count is the low 16 bits of the saturating counter.
	generate
		if (COUNT_BITS >= CNT_W) begin : g_cnt_trunc
			assign count_out = count_d[CNT_W-1:0];
		end else begin : g_cnt_ext
			assign count_out = {{(CNT_W-COUNT_BITS){1'b0}}, count_d};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			utf8_enable_q <= cfg_data;
		end
	end

	// Per-string state; the last byte of a string clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			acc_q        <= '0;
			count_q      <= '0;
			error_q      <= 1'b0;
		end else if (in_fire) begin
			if (last) begin
				bytes_left_q <= '0;
				acc_q        <= '0;
				count_q      <= '0;
				error_q      <= 1'b0;
			end else begin
				bytes_left_q <= bytes_left_d;
				acc_q        <= acc_d;
				count_q      <= count_d;
				error_q      <= error_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			cp_q              <= cp;
			count_out_q       <= count_out;
			flags_q.char_done <= done;
			flags_q.bad_lead  <= bad;
			flags_q.string_ok <= ok;
			last_q            <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(utf8sd_pkg::TDATA_OUT_W-CP_W-CNT_W){1'b0}}, count_out_q, cp_q};
	assign m_axis_tuser  = flags_q;
	assign m_axis_tlast  = last_q;

	// A byte never both completes a character and is an illegal lead.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[utf8sd_pkg::USER_CHAR_DONE] &&
		                    m_axis_tuser[utf8sd_pkg::USER_BAD_LEAD]))
		else $error("result marks both a completed character and a bad lead");

	// string_ok is only reported on the result that closes a string.
	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[utf8sd_pkg::USER_STRING_OK] |-> m_axis_tlast)
		else $error("string_ok set on a result that does not end a string");

	// After a string's last byte all per-string state is clear.
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> bytes_left_q == 2'd0 && count_q == '0 && !error_q)
		else $error("per-string state not cleared at string end");

	// An illegal lead inside a string marks the string as bad.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && bad && !last |=> error_q)
		else $error("illegal lead byte did not set the error mark");

endmodule

>>> tb/sv/utf8_stream_decoder_test.sv
// Self-checking testbench for utf8_stream_decoder: feeds string bytes with random gaps
// and back-pressure, predicts every decoded result and compares each result item.
// Depends on utf8sd_pkg and the utf8_stream_decoder RTL.
module utf8_stream_decoder_test;

	localparam int SETTLE      = 8;      // idle cycles before a register write and at the end
	localparam int QUIET_MAX   = 2000;   // cycles with no handshake at all before giving up
	localparam int RAND_ITEMS  = 800;

	// One decoded result, as the block reports it.
	typedef struct packed {
		logic [utf8sd_pkg::CP_W-1:0]        cp;
		logic                               done;
		logic                               bad;
		logic                               str_end;
		logic                               str_ok;
		logic [utf8sd_pkg::COUNT_OUT_W-1:0] count;
	} char_res_t;

	// One row of the directed stimulus. When typed is set, the expected result
	// (or its absence, through has) is taken from the row.
	typedef struct packed {
		logic       en;
		logic [7:0] b;
		logic       last;
		logic       typed;
		logic       has;
		char_res_t  res;
	} dir_row_t;

	localparam char_res_t NO_RES = '0;

	localparam dir_row_t DIR_TAB [0:25] = '{
		// Plain ASCII right after reset, lowest and highest value.
		'{1'b1, 8'h00, 1'b0, 1'b1, 1'b1, '{21'h0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd1}},
		'{1'b1, 8'h7F, 1'b0, 1'b1, 1'b1, '{21'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2}},
		// Two-, three- and four-byte characters.
		'{1'b1, 8'hC2, 1'b0, 1'b1, 1'b0, NO_RES},
		'{1'b1, 8'hA9, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'hE2, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h82, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'hAC, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'hF0, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h9F, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h98, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
		// Stray continuation, then lead bytes above the legal range, the last one
		// closing the string.
		'{1'b1, 8'h80, 1'b0, 1'b1, 1'b1, '{21'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd5}},
		'{1'b1, 8'hF8, 1'b0, 1'b1, 1'b1, '{21'h0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd5}},
		'{1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, '{21'h0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd5}},
		// Highest four-byte lead with all payload bits set gives the largest code point.
		'{1'b1, 8'hF7, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'hBF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'hBF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'hBF, 1'b1, 1'b1, 1'b1, '{21'h1FFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1}},
		// Overlong encoding is decoded as given.
		'{1'b1, 8'hC0, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
		// A character cut short by the end of the string is dropped.
		'{1'b1, 8'hE0, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h80, 1'b1, 1'b1, 1'b1, '{21'h0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
		// Decoding switched off in the middle of a character: it still completes.
		'{1'b1, 8'hDF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b0, 8'hBF, 1'b1, 1'b0, 1'b0, NO_RES},
		// With decoding off every byte is a character of its own.
		'{1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, '{21'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd1}},
		'{1'b0, 8'h80, 1'b1, 1'b1, 1'b1, '{21'h80, 1'b1, 1'b0, 1'b1, 1'b1, 16'd2}}
	};

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic                                   cfg_data = 1'b1;
	logic                                   s_axis_tvalid = 1'b0;
	logic                                   s_axis_tready;
	logic [7:0]                             s_axis_tdata = '0;
	logic                                   s_axis_tlast = 1'b0;
	logic                                   m_axis_tvalid;
	logic                                   m_axis_tready = 1'b0;
	logic [utf8sd_pkg::TDATA_OUT_W-1:0]     m_axis_tdata;
	logic [utf8sd_pkg::TUSER_OUT_W-1:0]     m_axis_tuser;
	logic                                   m_axis_tlast;

	// Directed expectation travelling with the byte on the bus.
	logic                                   row_typed = 1'b0;
	logic                                   row_has = 1'b0;
	char_res_t                              row_res = '0;

	// Local copy of the decoder state and its register.
	logic                                   utf8_on = 1'b1;
	utf8sd_pkg::bytes_left_t                bytes_due = '0;
	logic [utf8sd_pkg::CP_W-1:0]            acc = '0;
	logic [utf8sd_pkg::COUNT_OUT_W-1:0]     chars = '0;
	logic                                   err_seen = 1'b0;

	char_res_t              pending_chars [$];
	int                     mismatches = 0;
	int                     quiet = 0;
	int                     rand_items = 0;
	int                     stall_left = 0;
	bit                     steady = 1'b0;  // no gaps on either side while set
	logic                   cur_en = 1'b1;

	utf8_stream_decoder #(
		.COUNT_BITS(utf8sd_pkg::COUNT_BITS_DEFAULT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length: mostly none, often a few cycles, sometimes long.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic string fmt_res(input char_res_t r);
		return $sformatf("cp=%h done=%b bad=%b end=%b ok=%b count=%0d",
			r.cp, r.done, r.bad, r.str_end, r.str_ok, r.count);
	endfunction

	// Decodes one byte in the local state; has tells whether the byte yields a
	// result item. Per-string state clears once the last byte is seen.
	task automatic decode_byte(input logic [7:0] b, input logic last, output bit has,
			output char_res_t r);
		r = '0;
		if (bytes_due != 2'd0) begin
			acc = {acc[utf8sd_pkg::CP_W-7:0], b[5:0] & utf8sd_pkg::CONT_MASK[5:0]};
			bytes_due = bytes_due - 2'd1;
			if (bytes_due == 2'd0) begin
				r.done = 1'b1;
				r.cp = acc;
			end
		end else if (!utf8_on || b < utf8sd_pkg::ASCII_LIMIT) begin
			r.done = 1'b1;
			r.cp = {{(utf8sd_pkg::CP_W-8){1'b0}}, b};
		end else if (b < utf8sd_pkg::LEAD2_MIN || b > utf8sd_pkg::LEAD_MAX) begin
			r.bad = 1'b1;
			err_seen = 1'b1;
		end else if (b < utf8sd_pkg::LEAD3_MIN) begin
			acc = {{(utf8sd_pkg::CP_W-8){1'b0}}, b & utf8sd_pkg::LEAD2_MASK};
			bytes_due = 2'd1;
		end else if (b < utf8sd_pkg::LEAD4_MIN) begin
			acc = {{(utf8sd_pkg::CP_W-8){1'b0}}, b & utf8sd_pkg::LEAD3_MASK};
			bytes_due = 2'd2;
		end else begin
			acc = {{(utf8sd_pkg::CP_W-8){1'b0}}, b & utf8sd_pkg::LEAD4_MASK};
			bytes_due = 2'd3;
		end
		// The count holds at all ones instead of wrapping.
		if (r.done && chars != '1)
			chars = chars + 1'b1;
		r.count = chars;
		r.str_end = last;
		if (last)
			r.str_ok = !err_seen && bytes_due == 2'd0;
		has = r.done || r.bad || last;
		if (last) begin
			bytes_due = '0;
			acc = '0;
			chars = '0;
			err_seen = 1'b0;
		end
	endtask

	// Offers one byte after a random gap and returns at the edge that takes it.
	// tvalid is only lowered when a gap follows, so it never toggles within a step.
	task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
			input logic has, input char_res_t res);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		row_typed <= typed;
		row_has <= has;
		row_res <= res;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Writes utf8_enable once the block has drained. A lead byte leaves no result,
	// so a few extra cycles pass after the last result before the write.
	task automatic write_enable(input logic en);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_en = en;
	endtask

	function automatic logic [7:0] lead_byte(input int n_cont);
		case (n_cont)
			1: return utf8sd_pkg::LEAD2_MIN | 8'($urandom_range(0, 31));
			2: return utf8sd_pkg::LEAD3_MIN | 8'($urandom_range(0, 15));
			default: return utf8sd_pkg::LEAD4_MIN | 8'($urandom_range(0, 7));
		endcase
	endfunction

	// Mostly proper continuation bytes, now and then anything at all.
	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return utf8sd_pkg::ASCII_LIMIT | 8'($urandom_range(0, 63));
	endfunction

	// Builds one string of n_chars characters, mostly well formed, with stray
	// continuations, illegal leads and truncated characters mixed in.
	task automatic send_string(input int n_chars);
		logic [7:0] seq [$];
		int kind;
		int n_cont;
		int c;
		for (c = 0; c < n_chars; c++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				seq.push_back(8'($urandom_range(0, 127)));
			end else if (kind < 88) begin
				n_cont = (kind < 55) ? 1 : (kind < 72) ? 2 : 3;
				seq.push_back(lead_byte(n_cont));
				if ($urandom_range(0, 9) == 0)
					n_cont = $urandom_range(0, n_cont - 1);
				repeat (n_cont) seq.push_back(cont_byte());
			end else if (kind < 94) begin
				seq.push_back(utf8sd_pkg::ASCII_LIMIT | 8'($urandom_range(0, 63)));
			end else begin
				seq.push_back(8'($urandom_range(int'(utf8sd_pkg::LEAD_MAX) + 1, 255)));
			end
		end
		foreach (seq[i]) begin
			push_byte(seq[i], i == seq.size() - 1, 1'b0, 1'b0, NO_RES);
			rand_items++;
		end
	endtask

	// Ready side: random stalls unless a steady stretch is running.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: register writes and accepted bytes update the prediction, accepted
	// result items are checked against the oldest expectation. Everything here
	// samples values from before the edge.
	always @(posedge clk) begin
		char_res_t want;
		char_res_t got;
		bit has;
		bit busy;
		if (arst_n) begin
			busy = 1'b0;
			if (cfg_valid && cfg_ready) begin
				utf8_on = cfg_data;
				busy = 1'b1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast, has, want);
				if (row_typed) begin
					has = row_has;
					want = row_res;
				end
				if (has)
					pending_chars.push_back(want);
				busy = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.cp = m_axis_tdata[utf8sd_pkg::CP_W-1:0];
				got.count = m_axis_tdata[utf8sd_pkg::CP_W +: utf8sd_pkg::COUNT_OUT_W];
				got.done = m_axis_tuser[utf8sd_pkg::USER_CHAR_DONE];
				got.bad = m_axis_tuser[utf8sd_pkg::USER_BAD_LEAD];
				got.str_ok = m_axis_tuser[utf8sd_pkg::USER_STRING_OK];
				got.str_end = m_axis_tlast;
				busy = 1'b1;
				if (pending_chars.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got %s", $time, fmt_res(got));
				end else begin
					want = pending_chars.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected %s, got %s", $time, fmt_res(want),
							fmt_res(got));
					end
				end
			end
			quiet <= busy ? 0 : quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the register is rewritten whenever a row asks for
		// another setting.
		foreach (DIR_TAB[i]) begin
			if (DIR_TAB[i].en != cur_en)
				write_enable(DIR_TAB[i].en);
			push_byte(DIR_TAB[i].b, DIR_TAB[i].last, DIR_TAB[i].typed, DIR_TAB[i].has,
				DIR_TAB[i].res);
		end

		// Random phases with a random setting each. Some end inside a character,
		// so the next write lands mid-character.
		while (rand_items < RAND_ITEMS) begin
			write_enable(1'($urandom_range(0, 1)));
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(3, 8)) send_string($urandom_range(1, 10));
			if ($urandom_range(0, 2) == 0) begin
				push_byte(lead_byte($urandom_range(1, 3)), 1'b0, 1'b0, 1'b0, NO_RES);
				rand_items++;
			end
		end
		steady = 1'b0;

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
